/* rtl/dump_pkg.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// dump_pkg
// Shared types and constants of the depth-update message parser.
// ---------------------------------------------------------------------------
package dump_pkg;

	// message layout, in bytes
	localparam int HeaderBytes   = 8;
	localparam int BodyBytes     = 26;
	localparam int TimeBytes     = 8;
	localparam int GroupHdrBytes = 4;
	localparam int PriceBytes    = 8;
	localparam int EntryMinBytes = 16;

	// width of the shared byte counter used by header, body and group headers
	localparam int ByteIdxW = $clog2(BodyBytes);

	// parse phase of the current message
	typedef enum logic [2:0] {
		PH_HEADER  = 3'd0,
		PH_BODY    = 3'd1,
		PH_BID_HDR = 3'd2,
		PH_BID_ENT = 3'd3,
		PH_ASK_HDR = 3'd4,
		PH_ASK_ENT = 3'd5,
		PH_TRAILER = 3'd6
	} phase_t;

	// side of a book update
	localparam logic SideBuy  = 1'b0;
	localparam logic SideSell = 1'b1;

	// one payload byte
	typedef struct packed {
		logic [7:0] data_byte;
		logic       frame_end;
	} byte_item_t;

	// one book update
	typedef struct packed {
		logic               side;
		logic signed [63:0] price;
		logic signed [63:0] quantity;
		logic signed [63:0] event_time;
	} update_t;

	// result handed from the parser to the output stage
	typedef struct packed {
		logic    valid;
		update_t upd;
	} result_t;

endpackage : dump_pkg
`default_nettype wire

/* rtl/dump_stream_if.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// dump_stream_if
// Valid/ready stream channel carrying one item of payload type T.
// ---------------------------------------------------------------------------
interface dump_stream_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface : dump_stream_if
`default_nettype wire

/* rtl/dump_parser.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// dump_parser
// Byte-wise message parser: tracks the phase, assembles the event time and
// the price and quantity of each entry, and flags a finished entry.
// ---------------------------------------------------------------------------
module dump_parser (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                fire,
	input  wire dump_pkg::byte_item_t item,
	output dump_pkg::result_t        res
);
	import dump_pkg::*;

	phase_t               phase_q, phase_n;
	logic [ByteIdxW-1:0]  byte_idx_q, byte_idx_n;
	logic [63:0]          event_time_q, event_time_n;
	logic [15:0]          block_len_q, block_len_n;
	logic [15:0]          entries_left_q, entries_left_n;
	logic [15:0]          entry_pos_q, entry_pos_n;
	logic [63:0]          price_acc_q, price_acc_n;
	logic [63:0]          qty_acc_q, qty_acc_n;

	logic [7:0]           b;
	logic [63:0]          price_m, qty_m;
	logic                 entry_done;
	phase_t               ent_phase, skip_phase;

	assign b = item.data_byte;

	// entry bytes merged into the accumulators
	always_comb begin
		price_m = price_acc_q;
		qty_m   = qty_acc_q;
		if (entry_pos_q < 16'(PriceBytes)) begin
			price_m[8*entry_pos_q[2:0] +: 8] = b;
		end else if (entry_pos_q < 16'(EntryMinBytes)) begin
			qty_m[8*entry_pos_q[2:0] +: 8] = b;
		end
	end

	assign entry_done = ({1'b0, entry_pos_q} + 17'd1) >= {1'b0, block_len_q};

	// phases that follow a group header
	always_comb begin
		if (phase_q == PH_BID_HDR) begin
			ent_phase  = PH_BID_ENT;
			skip_phase = PH_ASK_HDR;
		end else begin
			ent_phase  = PH_ASK_ENT;
			skip_phase = PH_TRAILER;
		end
	end

	// next state and result
	always_comb begin
		phase_n        = phase_q;
		byte_idx_n     = byte_idx_q;
		event_time_n   = event_time_q;
		block_len_n    = block_len_q;
		entries_left_n = entries_left_q;
		entry_pos_n    = entry_pos_q;
		price_acc_n    = price_acc_q;
		qty_acc_n      = qty_acc_q;

		res.valid          = 1'b0;
		res.upd.side       = (phase_q == PH_ASK_ENT) ? SideSell : SideBuy;
		res.upd.price      = price_m;
		res.upd.quantity   = qty_m;
		res.upd.event_time = event_time_q;

		if (fire) begin
			case (phase_q)
				PH_HEADER: begin
					if (byte_idx_q == ByteIdxW'(HeaderBytes - 1)) begin
						byte_idx_n = '0;
						phase_n    = PH_BODY;
					end else begin
						byte_idx_n = byte_idx_q + 1'b1;
					end
				end
				PH_BODY: begin
					if (byte_idx_q < ByteIdxW'(TimeBytes)) begin
						event_time_n[8*byte_idx_q[2:0] +: 8] = b;
					end
					if (byte_idx_q == ByteIdxW'(BodyBytes - 1)) begin
						byte_idx_n = '0;
						phase_n    = PH_BID_HDR;
					end else begin
						byte_idx_n = byte_idx_q + 1'b1;
					end
				end
				PH_BID_HDR, PH_ASK_HDR: begin
					// block length then count, both little-endian
					case (byte_idx_q[1:0])
						2'd0:    block_len_n[7:0]     = b;
						2'd1:    block_len_n[15:8]    = b;
						2'd2:    entries_left_n[7:0]  = b;
						default: entries_left_n[15:8] = b;
					endcase
					if (byte_idx_q == ByteIdxW'(GroupHdrBytes - 1)) begin
						byte_idx_n  = '0;
						entry_pos_n = '0;
						price_acc_n = '0;
						qty_acc_n   = '0;
						if (entries_left_n == '0 || block_len_n == '0) begin
							phase_n = skip_phase;
						end else begin
							phase_n = ent_phase;
						end
					end else begin
						byte_idx_n = byte_idx_q + 1'b1;
					end
				end
				PH_BID_ENT, PH_ASK_ENT: begin
					if (entry_done) begin
						res.valid      = (block_len_q >= 16'(EntryMinBytes));
						entry_pos_n    = '0;
						price_acc_n    = '0;
						qty_acc_n      = '0;
						entries_left_n = entries_left_q - 1'b1;
						if (entries_left_n == '0) begin
							phase_n = (phase_q == PH_BID_ENT) ? PH_ASK_HDR : PH_TRAILER;
						end
					end else begin
						entry_pos_n = entry_pos_q + 1'b1;
						price_acc_n = price_m;
						qty_acc_n   = qty_m;
					end
				end
				default: begin
					phase_n = PH_TRAILER;
				end
			endcase

			// end of message: back to the header, partial entry dropped
			if (item.frame_end) begin
				phase_n     = PH_HEADER;
				byte_idx_n  = '0;
				entry_pos_n = '0;
				price_acc_n = '0;
				qty_acc_n   = '0;
			end
		end
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_HEADER;
			byte_idx_q     <= '0;
			event_time_q   <= '0;
			block_len_q    <= '0;
			entries_left_q <= '0;
			entry_pos_q    <= '0;
			price_acc_q    <= '0;
			qty_acc_q      <= '0;
		end else begin
			phase_q        <= phase_n;
			byte_idx_q     <= byte_idx_n;
			event_time_q   <= event_time_n;
			block_len_q    <= block_len_n;
			entries_left_q <= entries_left_n;
			entry_pos_q    <= entry_pos_n;
			price_acc_q    <= price_acc_n;
			qty_acc_q      <= qty_acc_n;
		end
	end

endmodule : dump_parser
`default_nettype wire

/* rtl/dump_out_stage.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// dump_out_stage
// Output register with a skid register, so that the parser keeps taking
// bytes while an update waits to be taken downstream.
// ---------------------------------------------------------------------------
module dump_out_stage (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire dump_pkg::result_t res,
	output logic                   can_take,
	dump_stream_if.source          updates
);
	import dump_pkg::*;

	logic    out_v_q, skid_v_q;
	update_t out_q, skid_q;
	logic    pop;

	assign pop      = out_v_q && updates.ready;
	assign can_take = !skid_v_q;

	assign updates.valid = out_v_q;
	assign updates.data  = out_q;

	// valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (pop) begin
				skid_v_q <= 1'b0;
			end
		end else if (res.valid) begin
			if (out_v_q && !pop) begin
				skid_v_q <= 1'b1;
			end else begin
				out_v_q <= 1'b1;
			end
		end else if (pop) begin
			out_v_q <= 1'b0;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (pop) begin
				out_q <= skid_q;
			end
		end else if (res.valid) begin
			if (out_v_q && !pop) begin
				skid_q <= res.upd;
			end else begin
				out_q <= res.upd;
			end
		end
	end

endmodule : dump_out_stage
`default_nettype wire

/* rtl/depth_update_message_parser.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// depth_update_message_parser
// Output: the update of the byte that completes an entry is registered in
//   the output register, or in the skid register while an update waits.
// Throughput: one byte per cycle while the skid register is empty.
// Reset: arst_n clears the parse state to the message header phase and
//   empties the output and skid registers; no clearing pass is needed.
// ---------------------------------------------------------------------------
module depth_update_message_parser (
	input  wire logic     clk,
	input  wire logic     arst_n,
	dump_stream_if.sink   bytes,
	dump_stream_if.source updates
);
	import dump_pkg::*;

	logic    fire;
	logic    can_take;
	result_t res;

	assign bytes.ready = can_take;
	assign fire        = bytes.valid && can_take;

	// parse state and entry assembly
	dump_parser u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.item   (bytes.data),
		.res    (res)
	);

	// result register and skid
	dump_out_stage u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.res      (res),
		.can_take (can_take),
		.updates  (updates)
	);

endmodule : depth_update_message_parser
`default_nettype wire

/* rtl/dump_checker.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// dump_checker
// Port-level checks of the depth-update message parser.
// ---------------------------------------------------------------------------
module dump_checker (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              in_valid,
	input wire logic              in_ready,
	input wire logic              in_frame_end,
	input wire logic              out_valid,
	input wire logic              out_ready,
	input wire dump_pkg::update_t out_data
);
	import dump_pkg::*;

	// an update only shows up after an accepted byte
	a_rise_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready))
		else $error("update appeared without an accepted byte");

	// the header byte after a frame end never completes an entry
	a_no_update_after_end: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && in_frame_end) |-> ##2 !$rose(out_valid))
		else $error("update emitted right after a frame end");

	// input is only held off while an update is waiting
	a_backpressure_source: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled with no update pending");

	// a stalled update holds
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
		else $error("stalled update changed or dropped");

endmodule : dump_checker

bind depth_update_message_parser dump_checker u_dump_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (bytes.valid),
	.in_ready     (bytes.ready),
	.in_frame_end (bytes.data.frame_end),
	.out_valid    (updates.valid),
	.out_ready    (updates.ready),
	.out_data     (updates.data)
);
`default_nettype wire
